[rtl/ffaa_pkg.sv]
// shared types and constants for the first-fit arena allocator
package ffaa_pkg;

   // request function codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // reset value of the cache size limit register
   localparam logic [6:0] LIMIT_RESET = 7'd100;

   // controller states, also sent to the datapath as the current operation
   typedef enum logic [26:0] {
      S_CLEAR     = 27'h0000001,
      S_IDLE      = 27'h0000002,
      S_CONV      = 27'h0000004,
      S_FHDR      = 27'h0000008,
      S_MODQ      = 27'h0000010,
      S_MODR      = 27'h0000020,
      S_DECIDE    = 27'h0000040,
      S_HIT_RD    = 27'h0000080,
      S_HIT       = 27'h0000100,
      S_PUSH      = 27'h0000200,
      S_EV_RD     = 27'h0000400,
      S_EV_W      = 27'h0000800,
      S_EV_HD     = 27'h0001000,
      S_MARK      = 27'h0002000,
      S_SINIT     = 27'h0004000,
      S_SH_RD     = 27'h0008000,
      S_SH        = 27'h0010000,
      S_SJ_RD     = 27'h0020000,
      S_SJ        = 27'h0040000,
      S_SPL       = 27'h0080000,
      S_SPL2      = 27'h0100000,
      S_FL_E      = 27'h0200000,
      S_FL_CK     = 27'h0400000,
      S_FL_W      = 27'h0800000,
      S_FL_L      = 27'h1000000,
      S_RESP_ZERO = 27'h2000000,
      S_RESP_FAIL = 27'h4000000
   } op_type;

   // command from controller to datapath
   typedef struct packed {
      op_type op;
      logic   accept;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_alloc;
      logic free_bad_addr;
      logic free_bad_hdr;
      logic cacheable;
      logic cache_hit;
      logic size_match;
      logic head_valid;
      logic budget_zero;
      logic rd_busy;
      logic lap_fail;
      logic fits;
      logic link_go;
      logic fe_last;
      logic clr_last;
   } stat_type;

endpackage

[rtl/ffaa_ram.sv]
// generic simple dual-port ram with registered read
module ffaa_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ffaa_ctrl.sv]
// allocator controller state machine
module ffaa_ctrl import ffaa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   op_type state_ff, state_in;
   logic   pass_ff, pass_in;
   op_type fail_next;

   // a failed first pass flushes the cache chains, a failed second pass reports
   assign fail_next = pass_ff ? S_RESP_FAIL : S_FL_E;

   // next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_CONV;
         end
         S_CONV: begin
            if (stat.is_alloc) state_in = S_MODQ;
            else if (stat.free_bad_addr) state_in = S_RESP_ZERO;
            else state_in = S_FHDR;
         end
         S_FHDR: begin
            state_in = stat.free_bad_hdr ? S_RESP_ZERO : S_MODQ;
         end
         S_MODQ: state_in = S_MODR;
         S_MODR: state_in = S_DECIDE;
         S_DECIDE: begin
            if (stat.is_alloc) begin
               if (stat.cacheable && stat.cache_hit) begin
                  state_in = S_HIT_RD;
               end else begin
                  state_in = S_SINIT;
                  pass_in  = 1'b0;
               end
            end else if (stat.cacheable) begin
               if (!stat.size_match && stat.head_valid) state_in = S_EV_RD;
               else state_in = S_PUSH;
            end else begin
               state_in = S_MARK;
            end
         end
         S_HIT_RD: state_in = S_HIT;
         S_HIT:    state_in = S_IDLE;
         S_PUSH:   state_in = S_IDLE;
         S_EV_RD:  state_in = S_EV_W;
         S_EV_W:   state_in = S_EV_HD;
         S_EV_HD:  state_in = S_MARK;
         S_MARK:   state_in = S_IDLE;
         S_SINIT:  state_in = S_SH_RD;
         S_SH_RD: begin
            state_in = stat.budget_zero ? fail_next : S_SH;
         end
         S_SH: begin
            if (!stat.rd_busy) state_in = S_SJ_RD;
            else if (stat.lap_fail) state_in = fail_next;
            else state_in = S_SH_RD;
         end
         S_SJ_RD: state_in = S_SJ;
         S_SJ: begin
            if (stat.rd_busy) begin
               if (stat.fits) state_in = S_SPL;
               else if (stat.lap_fail) state_in = fail_next;
               else state_in = S_SH_RD;
            end else begin
               state_in = stat.budget_zero ? fail_next : S_SJ_RD;
            end
         end
         S_SPL:  state_in = S_SPL2;
         S_SPL2: state_in = S_IDLE;
         S_FL_E: state_in = S_FL_CK;
         S_FL_CK: begin
            if (stat.link_go) state_in = S_FL_W;
            else if (stat.fe_last) state_in = S_SINIT;
            else state_in = S_FL_E;
         end
         S_FL_W:      state_in = S_FL_L;
         S_FL_L:      state_in = S_FL_CK;
         S_RESP_ZERO: state_in = S_IDLE;
         S_RESP_FAIL: state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
      // entering the flush marks the second pass
      if (state_in == S_FL_E && state_ff != S_FL_CK) pass_in = 1'b1;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign cmd.op     = state_ff;
   assign cmd.accept = start && (state_ff == S_IDLE);

endmodule

[rtl/ffaa_dp.sv]
// allocator datapath: arena memory, size cache, search and response registers
module ffaa_dp import ffaa_pkg::*; #(
   parameter int ARENA_WORDS   = 4096,
   parameter int CACHE_ENTRIES = 13,
   parameter int WORD_BYTES    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        req_func,
   input  logic [15:0] req_request_bytes,
   input  logic [11:0] req_block_address,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   output logic        rsp_strobe,
   output logic [11:0] rsp_granted_address,
   output logic        rsp_failed
);

   localparam int AW = $clog2(ARENA_WORDS);
   localparam int WW = AW + 1;
   localparam int XW = AW + 1;
   localparam int EW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int BW = AW + 3;
   localparam logic [XW-1:0] N_X      = XW'(ARENA_WORDS);
   localparam logic [AW-1:0] LAST_IDX = AW'(ARENA_WORDS - 1);
   localparam logic [BW-1:0] SEARCH_BUDGET = BW'(4 * ARENA_WORDS);
   localparam logic [AW:0]   FLUSH_BUDGET  = (AW+1)'(ARENA_WORDS);
   localparam int CONV_SHIFT = 21;
   localparam logic [21:0] CONV_MUL  = 22'((2**21 + WORD_BYTES - 1) / WORD_BYTES);
   localparam logic [16:0] BYTE_BIAS = 17'(2 * WORD_BYTES - 1);
   localparam int MOD_SHIFT = 13;
   localparam logic [13:0] MOD_MUL   = 14'((2**13 + CACHE_ENTRIES - 1) / CACHE_ENTRIES);
   localparam logic [4:0]  ENTRIES_C = 5'(CACHE_ENTRIES);
   localparam logic [EW-1:0] FE_LAST = EW'(CACHE_ENTRIES - 1);

   // latched request
   logic        func_ff, func_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [11:0] addr_ff, addr_in;

   // working registers
   logic [6:0]    limit_ff, limit_in;
   logic [16:0]   nw_ff, nw_in;
   logic [6:0]    quot_ff, quot_in;
   logic [EW-1:0] e_ff, e_in;
   logic [XW-1:0] p_ff, p_in;
   logic [WW-1:0] h_ff, h_in;
   logic [AW-1:0] q_ff, q_in;
   logic [AW-1:0] start_ff, start_in;
   logic          laps_ff, laps_in;
   logic [BW-1:0] budget_ff, budget_in;
   logic [EW-1:0] fe_ff, fe_in;
   logic [WW-1:0] link_ff, link_in;
   logic [AW:0]   fbud_ff, fbud_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rd_oor_ff;

   // size cache
   logic [6:0]    size_ff [CACHE_ENTRIES];
   logic [6:0]    size_in [CACHE_ENTRIES];
   logic [WW-1:0] head_ff [CACHE_ENTRIES];
   logic [WW-1:0] head_in [CACHE_ENTRIES];

   // response
   logic        strobe_ff, strobe_in;
   logic [11:0] grant_ff, grant_in;
   logic        failed_ff, failed_in;

   // memory ports
   logic          wr_req;
   logic [XW-1:0] wr_idx;
   logic [WW-1:0] wr_data;
   logic [XW-1:0] rd_idx;
   logic [WW-1:0] ram_rd;

   // derived values
   logic [WW-1:0] rdata;
   logic [AW-1:0] rd_link, h_link, adv_link, head_link, link_idx;
   logic [EW-1:0] cidx;
   logic [6:0]    size_cur;
   logic [WW-1:0] head_cur;
   logic [38:0]   conv_prod;
   logic [20:0]   mod_prod;
   logic [11:0]   rem_sub;
   logic [16:0]   a_m1;
   logic [16:0]   gsum;
   logic [17:0]   p_plus_nw;
   logic          size_match;
   logic          lap_back;

   ffaa_ram #(
      .WIDTH (WW),
      .DEPTH (ARENA_WORDS)
   ) u_arena (
      .clock   (clock),
      .wr_en   (wr_req && (wr_idx < N_X)),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (ram_rd)
   );

   // out of range reads return zero
   assign rdata     = rd_oor_ff ? '0 : ram_rd;
   assign rd_link   = rdata[WW-1:1];
   assign h_link    = h_ff[WW-1:1];
   assign link_idx  = link_ff[WW-1:1];
   assign cidx      = (cmd.op == S_FL_E || cmd.op == S_FL_CK) ? fe_ff : e_ff;
   assign size_cur  = size_ff[cidx];
   assign head_cur  = head_ff[cidx];
   assign head_link = head_cur[WW-1:1];

   // arithmetic
   assign conv_prod  = 39'(17'(bytes_ff) + BYTE_BIAS) * 39'(CONV_MUL);
   assign mod_prod   = 21'(nw_ff[6:0]) * 21'(MOD_MUL);
   assign rem_sub    = 12'(quot_ff) * 12'(ENTRIES_C);
   assign a_m1       = 17'(addr_ff) - 17'd1;
   assign gsum       = 17'(p_ff) + 17'd1;
   assign p_plus_nw  = 18'(p_ff) + 18'(nw_ff);
   assign size_match = (17'(size_cur) == nw_ff);
   assign adv_link   = (cmd.op == S_SH) ? rd_link : h_link;
   assign lap_back   = (XW'(adv_link) <= p_ff);

   // status
   assign stat.is_alloc      = (func_ff == FUNC_ALLOC);
   assign stat.free_bad_addr = (addr_ff == 12'd0) || (17'(addr_ff) > 17'(ARENA_WORDS));
   assign stat.free_bad_hdr  = !rdata[0] || (XW'(rd_link) <= p_ff);
   assign stat.cacheable     = (nw_ff < 17'(limit_ff)) && (nw_ff > 17'd2);
   assign stat.cache_hit     = head_cur[0] && size_match;
   assign stat.size_match    = size_match;
   assign stat.head_valid    = head_cur[0];
   assign stat.budget_zero   = (budget_ff == '0);
   assign stat.rd_busy       = rdata[0];
   assign stat.lap_fail      = lap_back && laps_ff;
   assign stat.fits          = (18'(h_link) >= p_plus_nw);
   assign stat.link_go       = link_ff[0] && (fbud_ff != '0);
   assign stat.fe_last       = (fe_ff == FE_LAST);
   assign stat.clr_last      = (clr_ff == LAST_IDX);

   // memory address and write selection
   always_comb begin
      wr_req  = 1'b0;
      wr_idx  = p_ff;
      wr_data = '0;
      rd_idx  = p_ff;
      case (cmd.op)
         S_CLEAR: begin
            wr_req = 1'b1;
            wr_idx = XW'(clr_ff);
            if (clr_ff == '0) wr_data = {LAST_IDX, 1'b0};
            else if (clr_ff == LAST_IDX) wr_data = {{AW{1'b0}}, 1'b1};
            else wr_data = '0;
         end
         S_CONV:   rd_idx = a_m1[XW-1:0];
         S_HIT_RD: rd_idx = XW'(head_link) + XW'(1);
         S_PUSH: begin
            wr_req  = 1'b1;
            wr_idx  = p_ff + XW'(1);
            wr_data = head_cur;
         end
         S_EV_RD: rd_idx = XW'(head_link);
         S_EV_W: begin
            wr_req  = 1'b1;
            wr_idx  = XW'(q_ff);
            wr_data = {rdata[WW-1:1], 1'b0};
            rd_idx  = XW'(q_ff) + XW'(1);
         end
         S_MARK: begin
            wr_req  = 1'b1;
            wr_data = {h_link, 1'b0};
         end
         S_SJ_RD: rd_idx = XW'(h_link);
         S_SJ: begin
            wr_req  = !rdata[0] && (budget_ff != '0);
            wr_data = {rd_link, 1'b0};
         end
         S_SPL: begin
            wr_req  = (h_link > q_ff);
            wr_idx  = XW'(q_ff);
            wr_data = {h_link, 1'b0};
         end
         S_SPL2: begin
            wr_req  = 1'b1;
            wr_data = {q_ff, 1'b1};
         end
         S_FL_CK: rd_idx = XW'(link_idx);
         S_FL_W: begin
            wr_req  = 1'b1;
            wr_idx  = XW'(link_idx);
            wr_data = {rdata[WW-1:1], 1'b0};
            rd_idx  = XW'(link_idx) + XW'(1);
         end
         default: begin
            wr_req = 1'b0;
         end
      endcase
   end

   // register next values
   always_comb begin
      func_in   = func_ff;
      bytes_in  = bytes_ff;
      addr_in   = addr_ff;
      limit_in  = csr_we ? csr_wdata : limit_ff;
      nw_in     = nw_ff;
      quot_in   = quot_ff;
      e_in      = e_ff;
      p_in      = p_ff;
      h_in      = h_ff;
      q_in      = q_ff;
      start_in  = start_ff;
      laps_in   = laps_ff;
      budget_in = budget_ff;
      fe_in     = fe_ff;
      link_in   = link_ff;
      fbud_in   = fbud_ff;
      clr_in    = clr_ff;
      size_in   = size_ff;
      head_in   = head_ff;
      strobe_in = 1'b0;
      grant_in  = grant_ff;
      failed_in = failed_ff;
      if (cmd.accept) begin
         func_in  = req_func;
         bytes_in = req_request_bytes;
         addr_in  = req_block_address;
      end
      case (cmd.op)
         S_CLEAR: clr_in = clr_ff + AW'(1);
         S_CONV: begin
            nw_in = conv_prod[CONV_SHIFT +: 17];
            p_in  = a_m1[XW-1:0];
         end
         S_FHDR: begin
            h_in  = rdata;
            nw_in = 17'(rd_link) - 17'(p_ff);
         end
         S_MODQ: quot_in = mod_prod[MOD_SHIFT +: 7];
         S_MODR: e_in = EW'(12'(nw_ff[6:0]) - rem_sub);
         S_HIT_RD: p_in = XW'(head_link);
         S_HIT: begin
            head_in[e_ff] = rdata;
            strobe_in     = 1'b1;
            grant_in      = gsum[11:0];
            failed_in     = 1'b0;
         end
         S_PUSH: begin
            if (!size_match) size_in[e_ff] = nw_ff[6:0];
            head_in[e_ff] = {p_ff[AW-1:0], 1'b1};
            strobe_in     = 1'b1;
            grant_in      = '0;
            failed_in     = 1'b0;
         end
         S_EV_RD: q_in = head_link;
         S_EV_HD: head_in[e_ff] = rdata;
         S_MARK: begin
            start_in  = p_ff[AW-1:0];
            strobe_in = 1'b1;
            grant_in  = '0;
            failed_in = 1'b0;
         end
         S_SINIT: begin
            p_in      = XW'(start_ff);
            laps_in   = 1'b0;
            budget_in = SEARCH_BUDGET;
            fe_in     = '0;
         end
         S_SH_RD: begin
            if (budget_ff != '0) budget_in = budget_ff - BW'(1);
         end
         S_SH: begin
            if (rdata[0]) begin
               p_in = XW'(rd_link);
               if (lap_back) laps_in = 1'b1;
            end else begin
               h_in = rdata;
            end
         end
         S_SJ: begin
            if (rdata[0]) begin
               start_in = p_ff[AW-1:0];
               if (stat.fits) begin
                  q_in = p_plus_nw[AW-1:0];
               end else begin
                  p_in = XW'(h_link);
                  if (lap_back) laps_in = 1'b1;
               end
            end else if (budget_ff != '0) begin
               budget_in = budget_ff - BW'(1);
               h_in      = {rd_link, 1'b0};
            end
         end
         S_SPL2: begin
            strobe_in = 1'b1;
            grant_in  = gsum[11:0];
            failed_in = 1'b0;
         end
         S_FL_E: begin
            link_in = head_cur;
            fbud_in = FLUSH_BUDGET;
         end
         S_FL_CK: begin
            if (stat.link_go) begin
               fbud_in = fbud_ff - (AW+1)'(1);
            end else begin
               head_in[fe_ff] = '0;
               if (fe_ff != FE_LAST) fe_in = fe_ff + EW'(1);
            end
         end
         S_FL_L: link_in = rdata;
         S_RESP_ZERO: begin
            strobe_in = 1'b1;
            grant_in  = '0;
            failed_in = 1'b0;
         end
         S_RESP_FAIL: begin
            strobe_in = 1'b1;
            grant_in  = '0;
            failed_in = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         start_ff  <= '0;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            size_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         limit_ff  <= limit_in;
         start_ff  <= start_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
         size_ff   <= size_in;
         head_ff   <= head_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      bytes_ff  <= bytes_in;
      addr_ff   <= addr_in;
      nw_ff     <= nw_in;
      quot_ff   <= quot_in;
      e_ff      <= e_in;
      p_ff      <= p_in;
      h_ff      <= h_in;
      q_ff      <= q_in;
      laps_ff   <= laps_in;
      budget_ff <= budget_in;
      fe_ff     <= fe_in;
      link_ff   <= link_in;
      fbud_ff   <= fbud_in;
      grant_ff  <= grant_in;
      failed_ff <= failed_in;
      rd_oor_ff <= (rd_idx >= N_X);
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_granted_address = grant_ff;
   assign rsp_failed          = failed_ff;

endmodule

[rtl/first_fit_arena_allocator.sv]
// top level of the circular first-fit arena allocator
//
// One request at a time: a request transfers when start is high and busy is low,
// and its single result appears on rsp_* for one cycle with rsp_strobe; the
// receiver cannot stall, so sample it then. After reset the block is busy while
// it initializes the arena memory, one word a cycle
// (csr writes are taken during that time). Each arena access is one read of the
// registered-read arena memory, so timing follows the headers touched. The result
// strobe comes in the first idle cycle. A free takes longer when it evicts a cached
// block, and a searching allocate takes longer than a cache-hit allocate, growing
// with every header read, every neighbor check of an idle block (one more check
// per join) and the split. A failed search adds a flush of all cache chains and a
// second search.
module first_fit_arena_allocator import ffaa_pkg::*; #(
   parameter int ARENA_WORDS   = 4096,
   parameter int CACHE_ENTRIES = 13,
   parameter int WORD_BYTES    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [15:0] req_request_bytes,
   input  logic [11:0] req_block_address,
   output logic        rsp_strobe,
   output logic [11:0] rsp_granted_address,
   output logic        rsp_failed,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   ffaa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   ffaa_dp #(
      .ARENA_WORDS   (ARENA_WORDS),
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .WORD_BYTES    (WORD_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_func            (req_func),
      .req_request_bytes   (req_request_bytes),
      .req_block_address   (req_block_address),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_strobe          (rsp_strobe),
      .rsp_granted_address (rsp_granted_address),
      .rsp_failed          (rsp_failed)
   );

`ifndef SYNTHESIS
   // an accepted transfer keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a request");

   // a failed allocation never carries an address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_failed |-> rsp_granted_address == 12'd0)
      else $error("failed result with nonzero address");

   // results are never back to back
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe repeated");

   // a result is only delivered once the block has gone idle
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while still busy");
`endif

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the first-fit arena allocator
module tb;
   import ffaa_pkg::*;

   localparam int unsigned ARENA   = 4096;
   localparam int unsigned ENTRIES = 13;
   localparam int unsigned WBYTES  = 4;
   localparam int unsigned WATCHDOG_LIMIT = 400000;

   typedef struct {
      logic [11:0] granted_address;
      logic        failed;
   } grant_type;

   // queue of expected grants, checked in order of arrival
   class grant_scoreboard;
      grant_type pending[$];
      int        errors;

      function void note_request(grant_type g);
         pending.push_back(g);
      endfunction

      function void check_grant(logic [11:0] addr, logic fail);
         grant_type g;
         if (pending.size() == 0) begin
            $display("%0t: unexpected grant addr=%0d failed=%0d", $time, addr, fail);
            errors++;
            return;
         end
         g = pending.pop_front();
         if (addr !== g.granted_address) begin
            $display("%0t: granted_address expected %0d actual %0d",
                     $time, g.granted_address, addr);
            errors++;
         end
         if (fail !== g.failed) begin
            $display("%0t: failed expected %0d actual %0d", $time, g.failed, fail);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [15:0] req_request_bytes;
   logic [11:0] req_block_address;
   logic        rsp_strobe;
   logic [11:0] rsp_granted_address;
   logic        rsp_failed;
   logic        csr_we;
   logic [6:0]  csr_wdata;

   first_fit_arena_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_request_bytes(req_request_bytes),
      .req_block_address(req_block_address), .rsp_strobe(rsp_strobe),
      .rsp_granted_address(rsp_granted_address), .rsp_failed(rsp_failed),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   grant_scoreboard sb = new();

   // shadow allocator state
   logic [12:0]  arena [ARENA];
   int unsigned  search_start;
   int unsigned  cached_size [ENTRIES];
   int unsigned  cache_head [ENTRIES];
   int unsigned  cache_limit;
   int unsigned  live_blocks[$];
   int unsigned  idle_count;

   function automatic int unsigned arena_rd(int unsigned i);
      return (i < ARENA) ? int'(arena[i]) : 0;
   endfunction

   function automatic void arena_wr(int unsigned i, int unsigned v);
      if (i < ARENA) arena[i] = v[12:0];
   endfunction

   function automatic int unsigned hdr(int unsigned idx, int unsigned flag);
      return (idx << 1) | (flag & 1);
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < ARENA; i++) arena[i] = '0;
      arena[0] = 13'(hdr(ARENA - 1, 0));
      arena[ARENA - 1] = 13'(hdr(0, 1));
      search_start = 0;
      for (int e = 0; e < ENTRIES; e++) begin
         cached_size[e] = 0;
         cache_head[e] = 0;
      end
      cache_limit = LIMIT_RESET;
   endfunction

   // release every cached block back to the arena as idle
   function automatic void flush_cache_chains();
      int unsigned link, budget, i;
      for (int e = 0; e < ENTRIES; e++) begin
         link = cache_head[e];
         budget = ARENA;
         while ((link & 1) && budget > 0) begin
            i = link >> 1;
            budget--;
            arena_wr(i, arena_rd(i) & ~32'd1);
            link = arena_rd(i + 1);
         end
         cache_head[e] = 0;
      end
   endfunction

   // circular first-fit walk joining idle neighbors
   function automatic bit first_fit_search(int unsigned nw, output int unsigned found);
      int unsigned p, laps, budget, h, q, qh;
      p = search_start;
      laps = 0;
      budget = 4 * ARENA;
      found = 0;
      forever begin
         if (budget == 0) return 1'b0;
         budget--;
         h = arena_rd(p);
         if ((h & 1) == 0) begin
            forever begin
               q = h >> 1;
               qh = arena_rd(q);
               if (qh & 1) break;
               if (budget == 0) return 1'b0;
               budget--;
               h = hdr(qh >> 1, 0);
               arena_wr(p, h);
            end
            search_start = p;
            if (q >= p + nw) begin
               found = p;
               return 1'b1;
            end
         end
         q = p;
         p = h >> 1;
         if (p <= q) begin
            laps++;
            if (laps > 1) return 1'b0;
         end
      end
   endfunction

   function automatic grant_type predict_allocate(int unsigned bytes);
      grant_type g;
      int unsigned nw, e, p, h, q;
      g.granted_address = '0;
      g.failed = 1'b0;
      nw = (bytes + 2 * WBYTES - 1) / WBYTES;
      if (nw < cache_limit && nw > 2) begin
         e = nw % ENTRIES;
         if ((cache_head[e] & 1) && cached_size[e] == nw) begin
            p = cache_head[e] >> 1;
            cache_head[e] = arena_rd(p + 1) & 32'h1FFFF;
            g.granted_address = 12'(p + 1);
            return g;
         end
      end
      if (!first_fit_search(nw, p)) begin
         flush_cache_chains();
         if (!first_fit_search(nw, p)) begin
            g.failed = 1'b1;
            return g;
         end
      end
      q = p + nw;
      h = arena_rd(p);
      if ((h >> 1) > q) arena_wr(q, hdr(h >> 1, 0));
      arena_wr(p, hdr(q, 1));
      g.granted_address = 12'(p + 1);
      return g;
   endfunction

   function automatic void predict_free(int unsigned a);
      int unsigned p, h, n, nw, e, v;
      bit cache_it;
      if (a == 0 || a > ARENA) return;
      p = a - 1;
      h = arena_rd(p);
      n = h >> 1;
      if ((h & 1) == 0 || n <= p) return;
      nw = n - p;
      if (nw < cache_limit && nw > 2) begin
         e = nw % ENTRIES;
         cache_it = 1'b1;
         if (nw != cached_size[e]) begin
            if (cache_head[e] & 1) begin
               // a different size owns the entry: evict its head
               v = cache_head[e] >> 1;
               arena_wr(v, arena_rd(v) & ~32'd1);
               cache_head[e] = arena_rd(v + 1) & 32'h1FFFF;
               cache_it = 1'b0;
            end else begin
               cached_size[e] = nw & 32'h7F;
            end
         end
         if (cache_it) begin
            arena_wr(p + 1, cache_head[e]);
            cache_head[e] = hdr(p, 1);
            return;
         end
      end
      search_start = p;
      arena_wr(p, h & ~32'd1);
   endfunction

   // result monitor and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_grant(rsp_granted_address, rsp_failed);
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("** first_fit_arena_allocator: FAILED **");
            $finish;
         end
      end
   end

   // one request transfer, predicted at the accepting edge
   task automatic send_request(logic func, int unsigned bytes, int unsigned addr);
      grant_type g;
      start <= 1'b1;
      req_func <= func;
      req_request_bytes <= bytes[15:0];
      req_block_address <= addr[11:0];
      do @(posedge clock); while (busy);
      g.granted_address = '0;
      g.failed = 1'b0;
      if (func == FUNC_ALLOC) begin
         g = predict_allocate(bytes[15:0]);
         if (!g.failed) live_blocks.push_back(g.granted_address);
      end else begin
         predict_free(addr[11:0]);
      end
      sb.note_request(g);
   endtask

   task automatic pause_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      pause_cycles(1);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      csr_we <= 1'b1;
      csr_wdata <= v[6:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cache_limit = v & 32'h7F;
   endtask

   // free a live block; keep it listed now and then to get repeated frees
   task automatic free_live(bit keep);
      int k;
      int unsigned a;
      k = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[k];
      if (!keep) live_blocks.delete(k);
      send_request(FUNC_FREE, 0, a);
   endtask

   task automatic random_phase(int count, int gap_pct);
      int r;
      int unsigned bytes;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 45 && live_blocks.size() > 0) begin
            free_live($urandom_range(99) < 8);
         end else if (r < 50) begin
            send_request(FUNC_FREE, $urandom, $urandom_range(4095));
         end else begin
            r = $urandom_range(99);
            if (r < 70) bytes = $urandom_range(200);
            else if (r < 90) bytes = $urandom_range(2000);
            else if (r < 95) bytes = $urandom_range(65535);
            else bytes = $urandom_range(16);
            send_request(FUNC_ALLOC, bytes, $urandom_range(4095));
         end
         if ($urandom_range(99) < gap_pct) pause_cycles($urandom_range(1, 20));
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= FUNC_ALLOC;
      req_request_bytes <= '0;
      req_block_address <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      idle_count = 0;
      shadow_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: size extremes, cache hits, eviction, bad frees, flush on failure
      send_request(FUNC_ALLOC, 0, 0);
      send_request(FUNC_ALLOC, 1, 0);
      send_request(FUNC_ALLOC, 5, 0);
      send_request(FUNC_ALLOC, 65535, 12'hFFF);
      send_request(FUNC_ALLOC, 388, 0);
      send_request(FUNC_ALLOC, 400, 0);
      send_request(FUNC_FREE, 0, 0);
      send_request(FUNC_FREE, 16'hFFFF, 4095);
      send_request(FUNC_FREE, 0, live_blocks[2]);
      send_request(FUNC_FREE, 0, live_blocks[2]);
      send_request(FUNC_ALLOC, 5, 0);
      send_request(FUNC_ALLOC, 5, 0);
      send_request(FUNC_ALLOC, 56, 0);
      send_request(FUNC_FREE, 0, live_blocks[live_blocks.size() - 1]);
      send_request(FUNC_FREE, 0, live_blocks[4]);
      send_request(FUNC_FREE, 0, live_blocks[5]);
      send_request(FUNC_FREE, 0, live_blocks[5]);
      send_request(FUNC_FREE, 0, live_blocks[0]);
      send_request(FUNC_ALLOC, 15000, 0);
      send_request(FUNC_ALLOC, 1200, 0);
      send_request(FUNC_ALLOC, 1200, 0);
      live_blocks.delete();
      drain();

      // random phases across cache limit settings and sender idling
      write_limit(127);
      random_phase(250, 0);
      drain();
      write_limit(3);
      random_phase(250, 65);
      drain();
      write_limit($urandom_range(4, 126));
      random_phase(250, 0);
      drain();
      write_limit(100);
      random_phase(250, 30);
      drain();

      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("** first_fit_arena_allocator: PASSED **");
      end else begin
         $display("** first_fit_arena_allocator: FAILED **");
      end
      $finish;
   end
endmodule
